FILE: rtl/rpe_pkg.sv
// Shared constants, command/status types and series tables for the ring point emitter.
package rpe_pkg;

  // Phase accumulator width and the internal angle width
  localparam int PHASE_BITS = 16;
  localparam int ANG_W      = 24;

  // Iterative divider geometry
  localparam int DIVD_W    = 33;
  localparam int DIVS_W    = 16;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RING_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_JITTER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEVATION     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS         = 2'd3;

  // Q2.30 constants
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI4_Q30 = 32'd843314857;

  // Series term codes: sine terms first, then cosine terms
  localparam logic [2:0] TERM_SIN_FIRST = 3'd0;
  localparam logic [2:0] TERM_SIN_LAST  = 3'd3;
  localparam logic [2:0] TERM_COS_FIRST = 3'd4;
  localparam logic [2:0] TERM_COS_LAST  = 3'd7;

  // Reciprocals floor(2^32 / d) of the series divisors
  localparam logic [31:0] RCP_72 = 32'((64'h1_0000_0000) / 72);
  localparam logic [31:0] RCP_42 = 32'((64'h1_0000_0000) / 42);
  localparam logic [31:0] RCP_20 = 32'((64'h1_0000_0000) / 20);
  localparam logic [31:0] RCP_6  = 32'((64'h1_0000_0000) / 6);
  localparam logic [31:0] RCP_56 = 32'((64'h1_0000_0000) / 56);
  localparam logic [31:0] RCP_30 = 32'((64'h1_0000_0000) / 30);
  localparam logic [31:0] RCP_12 = 32'((64'h1_0000_0000) / 12);
  localparam logic [31:0] RCP_2  = 32'((64'h1_0000_0000) / 2);

  // Datapath operations
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_DIV_ELEV,
    OP_DIV_STEPS,
    OP_STORE_INCR,
    OP_ANG,
    OP_MUL_X,
    OP_MUL_XX,
    OP_RCP,
    OP_CORR,
    OP_MUL_X2A,
    OP_MUL_XA,
    OP_RND_S,
    OP_RND_C,
    OP_FOLD,
    OP_STORE_ELEV,
    OP_SPR_MUL,
    OP_SPR_RND,
    OP_RM_MUL,
    OP_RM_RND,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] idx;       // series term or product select
    logic       src_elev;  // angle comes from the elevation quotient
    logic       in_take;   // input request accepted
    logic       cfg_take;  // configuration request accepted
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

  // Divisor of each series term
  function automatic logic [6:0] term_div(input logic [2:0] term);
    logic [6:0] d;
    case (term)
      3'd0:    d = 7'd72;
      3'd1:    d = 7'd42;
      3'd2:    d = 7'd20;
      3'd3:    d = 7'd6;
      3'd4:    d = 7'd56;
      3'd5:    d = 7'd30;
      3'd6:    d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // Reciprocal of each series term divisor
  function automatic logic [31:0] term_rcp(input logic [2:0] term);
    logic [31:0] m;
    case (term)
      3'd0:    m = RCP_72;
      3'd1:    m = RCP_42;
      3'd2:    m = RCP_20;
      3'd3:    m = RCP_6;
      3'd4:    m = RCP_56;
      3'd5:    m = RCP_30;
      3'd6:    m = RCP_12;
      default: m = RCP_2;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/rpe_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module rpe_divider
  import rpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    divisor_r;
  logic [DIVD_W-1:0]    quo_r;

  logic [DIVS_W:0]      trial;
  logic [DIVS_W:0]      diff;
  logic                 fits;
  logic [DIVS_W-1:0]    rem_nxt;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    diff    = trial - {1'b0, divisor_r};
    fits    = (trial >= {1'b0, divisor_r});
    rem_nxt = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
  end

  // Hold the busy flag and the step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift dividend bits in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      divisor_r <= divisor;
      quo_r     <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVD_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/rpe_datapath.sv
// Datapath: registers, shared multiplier, sine/cosine series and rounding products.
module rpe_datapath
  import rpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [15:0]           in_random_phase,
  input  logic signed [15:0]    in_random_jitter,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic signed [17:0]    pos_x,
  output logic signed [17:0]    pos_y,
  output logic signed [15:0]    vel_x,
  output logic signed [15:0]    vel_y,
  output logic signed [15:0]    vel_z
);

  localparam logic [8:0]  ELEV_FULL  = 9'd360;
  localparam logic [8:0]  ELEV_LOW   = 9'd90;
  localparam logic [8:0]  ELEV_HIGH  = 9'd270;
  // Turn fraction of d degrees is (d * 2^21 + 22) / 45; 45 via ceil(2^36 / 45)
  localparam logic [29:0] ELEV_BIAS  = 30'd22;
  localparam logic [31:0] ELEV_RCP   = 32'd1527099484;
  localparam logic signed [15:0] H_RESET = 16'sd16384;

  // Configuration and derived state
  logic [15:0]            ring_radius_r;
  logic [15:0]            radius_jitter_r;
  logic [8:0]             elevation_r;
  logic [15:0]            steps_r;
  logic [PHASE_BITS-1:0]  incr_r;
  logic [PHASE_BITS-1:0]  phase_r;
  logic signed [15:0]     se_r;
  logic signed [15:0]     h_r;

  // Working registers
  logic signed [15:0]     jitter_r;
  logic [2:0]             oct_r;
  logic [21:0]            r_r;
  logic [29:0]            x_r;
  logic [29:0]            x2_r;
  logic [29:0]            v_r;
  logic [30:0]            acc_r;
  logic [14:0]            sq_r;
  logic [14:0]            cq_r;
  logic signed [15:0]     sin_r;
  logic signed [15:0]     cos_r;
  logic [63:0]            prod_r;
  logic                   neg_r;
  logic signed [17:0]     reff_r;
  logic [17:0]            res_px_r;
  logic [17:0]            res_py_r;
  logic [15:0]            res_vx_r;
  logic [15:0]            res_vy_r;
  logic [17:0]            out_px_r;
  logic [17:0]            out_py_r;
  logic [15:0]            out_vx_r;
  logic [15:0]            out_vy_r;
  logic [15:0]            out_vz_r;

  // Divider hookup
  logic                   div_start;
  logic [DIVD_W-1:0]      div_dividend;
  logic [DIVS_W-1:0]      div_divisor;
  logic                   div_busy;
  logic [DIVD_W-1:0]      div_q;

  // Combinational helpers
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            mul_p;
  logic                   mul_neg;
  logic [23:0]            rp_ext;
  logic [23:0]            rp_sh;
  logic [ANG_W-1:0]       t_phase;
  logic [ANG_W-1:0]       t_ang;
  logic [21:0]            r_fold;
  logic [29:0]            x_val;
  logic [29:0]            v_val;
  logic [29:0]            q0;
  logic [6:0]             dv;
  logic [36:0]            qd;
  logic [30:0]            rem31;
  logic                   bump;
  logic [30:0]            rnd_s;
  logic [30:0]            rnd_c;
  logic signed [15:0]     sqs;
  logic signed [15:0]     cqs;
  logic signed [15:0]     sin_f;
  logic signed [15:0]     cos_f;
  logic [15:0]            habs;
  logic                   elev_neg;
  logic [8:0]             elev_mod;
  logic [29:0]            elev_num;
  logic [32:0]            spr_rnd;
  logic [18:0]            spr_q;
  logic [18:0]            spread;
  logic [18:0]            reff_sum;
  logic [32:0]            rm_rnd;
  logic [18:0]            rm_q;
  logic [18:0]            rm_val;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [17:0] abs18(input logic signed [17:0] v);
    return v[17] ? 18'(-v) : 18'(v);
  endfunction

  rpe_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign status.div_busy = div_busy;

  // Divider operands for the phase increment, numerator for the elevation angle
  always_comb begin
    elev_mod     = (elevation_r >= ELEV_FULL) ? (elevation_r - ELEV_FULL) : elevation_r;
    elev_num     = {elev_mod, 21'd0} + ELEV_BIAS;
    div_start    = (cmd.op == OP_DIV_STEPS);
    div_dividend = (DIVD_W'(1) << PHASE_BITS) + DIVD_W'(steps_r >> 1);
    div_divisor  = steps_r;
  end

  // Angle source and octant reduction
  always_comb begin
    rp_ext  = {in_random_phase, 8'h00};
    rp_sh   = rp_ext >> (ANG_W - PHASE_BITS);
    t_phase = ANG_W'(phase_r) << (ANG_W - PHASE_BITS);
    t_ang   = cmd.src_elev ? prod_r[59:36] : t_phase;
    r_fold  = t_ang[21] ? (22'h200000 - {1'b0, t_ang[20:0]}) : {1'b0, t_ang[20:0]};
    x_val   = prod_r[50:21];
    v_val   = (cmd.idx == TERM_COS_FIRST) ? x2_r : prod_r[59:30];
  end

  // Select the shared multiplier operands
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd.op)
      OP_DIV_ELEV: begin
        mul_a = 32'(elev_num);
        mul_b = ELEV_RCP;
      end
      OP_MUL_X: begin
        mul_a = 32'(r_r);
        mul_b = PI4_Q30;
      end
      OP_MUL_XX: begin
        mul_a = 32'(x_val);
        mul_b = 32'(x_val);
      end
      OP_RCP: begin
        mul_a = 32'(v_val);
        mul_b = term_rcp(cmd.idx);
      end
      OP_MUL_X2A: begin
        mul_a = 32'(x2_r);
        mul_b = 32'(acc_r);
      end
      OP_MUL_XA: begin
        mul_a = 32'(x_r);
        mul_b = 32'(acc_r);
      end
      OP_SPR_MUL: begin
        mul_a   = 32'(radius_jitter_r);
        mul_b   = 32'(abs16(jitter_r));
        mul_neg = jitter_r[15];
      end
      OP_RM_MUL: begin
        case (cmd.idx[1:0])
          2'd0: begin
            mul_a   = 32'(abs16(cos_r));
            mul_b   = 32'(abs18(reff_r));
            mul_neg = cos_r[15] ^ reff_r[17];
          end
          2'd1: begin
            mul_a   = 32'(abs16(sin_r));
            mul_b   = 32'(abs18(reff_r));
            mul_neg = sin_r[15] ^ reff_r[17];
          end
          2'd2: begin
            mul_a   = 32'(abs16(cos_r));
            mul_b   = 32'(abs16(h_r));
            mul_neg = cos_r[15] ^ h_r[15];
          end
          default: begin
            mul_a   = 32'(abs16(sin_r));
            mul_b   = 32'(abs16(h_r));
            mul_neg = sin_r[15] ^ h_r[15];
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Reciprocal correction, series rounding and octant fold
  always_comb begin
    q0    = prod_r[61:32];
    dv    = term_div(cmd.idx);
    qd    = q0 * dv;
    rem31 = 31'(v_r) - qd[30:0];
    bump  = (rem31 >= 31'(dv));
    rnd_s = 31'(prod_r[59:30]) + 31'd32768;
    rnd_c = acc_r + 31'd32768;
    sqs   = signed'({1'b0, sq_r});
    cqs   = signed'({1'b0, cq_r});
    case (oct_r)
      3'd0:    begin sin_f = sqs;  cos_f = cqs;  end
      3'd1:    begin sin_f = cqs;  cos_f = sqs;  end
      3'd2:    begin sin_f = cqs;  cos_f = -sqs; end
      3'd3:    begin sin_f = sqs;  cos_f = -cqs; end
      3'd4:    begin sin_f = -sqs; cos_f = -cqs; end
      3'd5:    begin sin_f = -cqs; cos_f = -sqs; end
      3'd6:    begin sin_f = -cqs; cos_f = sqs;  end
      default: begin sin_f = -sqs; cos_f = cqs;  end
    endcase
    habs     = abs16(cos_r);
    elev_neg = (elevation_r > ELEV_LOW) && (elevation_r < ELEV_HIGH);
  end

  // Signed rounding of the spread and of the output products
  always_comb begin
    spr_rnd  = 33'(prod_r[31:0]) + 33'd16384;
    spr_q    = {1'b0, spr_rnd[32:15]};
    spread   = neg_r ? (19'd0 - spr_q) : spr_q;
    reff_sum = 19'(ring_radius_r) + spread;
    rm_rnd   = 33'(prod_r[31:0]) + 33'd8192;
    rm_q     = rm_rnd[32:14];
    rm_val   = neg_r ? (19'd0 - rm_q) : rm_q;
  end

  // Hold configuration, phase and elevation-derived factors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_radius_r   <= 16'd256;
      radius_jitter_r <= '0;
      elevation_r     <= '0;
      steps_r         <= '0;
      incr_r          <= '0;
      phase_r         <= '0;
      se_r            <= '0;
      h_r             <= H_RESET;
    end else begin
      if (cmd.cfg_take) begin
        case (cfg_index)
          REG_RING_RADIUS:   ring_radius_r   <= cfg_data;
          REG_RADIUS_JITTER: radius_jitter_r <= cfg_data;
          REG_ELEVATION:     elevation_r     <= cfg_data[8:0];
          REG_STEPS:         steps_r         <= cfg_data;
          default:           steps_r         <= steps_r;
        endcase
      end
      if (cmd.in_take) begin
        phase_r <= (steps_r != 16'd0) ? (phase_r + incr_r) : rp_sh[PHASE_BITS-1:0];
      end
      if (cmd.op == OP_STORE_INCR) begin
        incr_r <= (steps_r == 16'd0) ? '0 : div_q[PHASE_BITS-1:0];
      end
      if (cmd.op == OP_STORE_ELEV) begin
        se_r <= sin_r;
        h_r  <= elev_neg ? -signed'(habs) : signed'(habs);
      end
    end
  end

  // Advance the working registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      jitter_r <= in_random_jitter;
    end
    case (cmd.op)
      OP_ANG: begin
        oct_r <= t_ang[23:21];
        r_r   <= r_fold;
      end
      OP_MUL_X: begin
        prod_r <= mul_p;
      end
      OP_MUL_XX: begin
        x_r    <= x_val;
        prod_r <= mul_p;
      end
      OP_RCP: begin
        v_r    <= v_val;
        prod_r <= mul_p;
        if (cmd.idx == TERM_SIN_FIRST) begin
          x2_r <= v_val;
        end
      end
      OP_CORR: begin
        acc_r <= Q30_ONE - 31'(q0) - 31'(bump);
      end
      OP_DIV_ELEV, OP_MUL_X2A, OP_MUL_XA: begin
        prod_r <= mul_p;
      end
      OP_RND_S: begin
        sq_r <= rnd_s[30:16];
      end
      OP_RND_C: begin
        cq_r <= rnd_c[30:16];
      end
      OP_FOLD: begin
        sin_r <= sin_f;
        cos_r <= cos_f;
      end
      OP_SPR_MUL, OP_RM_MUL: begin
        prod_r <= mul_p;
        neg_r  <= mul_neg;
      end
      OP_SPR_RND: begin
        reff_r <= signed'(reff_sum[17:0]);
      end
      OP_RM_RND: begin
        case (cmd.idx[1:0])
          2'd0:    res_px_r <= rm_val[17:0];
          2'd1:    res_py_r <= rm_val[17:0];
          2'd2:    res_vx_r <= rm_val[15:0];
          default: res_vy_r <= rm_val[15:0];
        endcase
      end
      OP_PUBLISH: begin
        out_px_r <= res_px_r;
        out_py_r <= res_py_r;
        out_vx_r <= res_vx_r;
        out_vy_r <= res_vy_r;
        out_vz_r <= se_r;
      end
      default: begin
        prod_r <= prod_r;
      end
    endcase
  end

  assign pos_x = signed'(out_px_r);
  assign pos_y = signed'(out_py_r);
  assign vel_x = signed'(out_vx_r);
  assign vel_y = signed'(out_vy_r);
  assign vel_z = signed'(out_vz_r);

endmodule

FILE: rtl/rpe_ctrl.sv
// Controller: sequences configuration jobs, the sine/cosine series and the output products.
module rpe_ctrl
  import rpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  dp_status_t           status,
  output dp_cmd_t              cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_STORE_INCR,
    ST_ANG,
    ST_MUL_X,
    ST_MUL_XX,
    ST_RCP,
    ST_CORR,
    ST_MUL_X2A,
    ST_MUL_XA,
    ST_RND_S,
    ST_RND_C,
    ST_FOLD,
    ST_STORE_ELEV,
    ST_SPR_MUL,
    ST_SPR_RND,
    ST_RM_MUL,
    ST_RM_RND,
    ST_PUBLISH
  } state_t;

  typedef enum logic [1:0] {
    JOB_ITEM,
    JOB_ELEV,
    JOB_STEPS
  } job_t;

  state_t     state_r;
  job_t       job_r;
  logic [2:0] term_r;
  logic       out_valid_r;
  logic       pub_ok;

  assign pub_ok     = !out_valid_r || out_tready;
  assign cfg_ready  = (state_r == ST_IDLE);
  assign in_tready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;

  // Decode the state into a datapath command
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_IDLE;
    cmd.idx      = term_r;
    cmd.src_elev = (job_r == JOB_ELEV);
    case (state_r)
      ST_IDLE: begin
        cmd.cfg_take = cfg_valid;
        cmd.in_take  = in_tvalid && !cfg_valid;
      end
      ST_DIV_GO:     cmd.op = (job_r == JOB_ELEV) ? OP_DIV_ELEV : OP_DIV_STEPS;
      ST_STORE_INCR: cmd.op = OP_STORE_INCR;
      ST_ANG:        cmd.op = OP_ANG;
      ST_MUL_X:      cmd.op = OP_MUL_X;
      ST_MUL_XX:     cmd.op = OP_MUL_XX;
      ST_RCP:        cmd.op = OP_RCP;
      ST_CORR:       cmd.op = OP_CORR;
      ST_MUL_X2A:    cmd.op = OP_MUL_X2A;
      ST_MUL_XA:     cmd.op = OP_MUL_XA;
      ST_RND_S:      cmd.op = OP_RND_S;
      ST_RND_C:      cmd.op = OP_RND_C;
      ST_FOLD:       cmd.op = OP_FOLD;
      ST_STORE_ELEV: cmd.op = OP_STORE_ELEV;
      ST_SPR_MUL:    cmd.op = OP_SPR_MUL;
      ST_SPR_RND:    cmd.op = OP_SPR_RND;
      ST_RM_MUL:     cmd.op = OP_RM_MUL;
      ST_RM_RND:     cmd.op = OP_RM_RND;
      ST_PUBLISH:    cmd.op = pub_ok ? OP_PUBLISH : OP_IDLE;
      default:       cmd.op = OP_IDLE;
    endcase
  end

  // Hold state, job, term count and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_ITEM;
      term_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_PUBLISH) && pub_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_ELEVATION) begin
              job_r   <= JOB_ELEV;
              state_r <= ST_DIV_GO;
            end else if (cfg_index == REG_STEPS) begin
              job_r   <= JOB_STEPS;
              state_r <= ST_DIV_GO;
            end
          end else if (in_tvalid) begin
            job_r   <= JOB_ITEM;
            state_r <= ST_ANG;
          end
        end
        ST_DIV_GO: state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (!status.div_busy) begin
            state_r <= (job_r == JOB_ELEV) ? ST_ANG : ST_STORE_INCR;
          end
        end
        ST_STORE_INCR: state_r <= ST_IDLE;
        ST_ANG: begin
          term_r  <= TERM_SIN_FIRST;
          state_r <= ST_MUL_X;
        end
        ST_MUL_X:  state_r <= ST_MUL_XX;
        ST_MUL_XX: state_r <= ST_RCP;
        ST_RCP:    state_r <= ST_CORR;
        ST_CORR: begin
          if (term_r == TERM_SIN_LAST) begin
            state_r <= ST_MUL_XA;
          end else if (term_r == TERM_COS_LAST) begin
            state_r <= ST_RND_C;
          end else begin
            term_r  <= term_r + 3'd1;
            state_r <= ST_MUL_X2A;
          end
        end
        ST_MUL_X2A: state_r <= ST_RCP;
        ST_MUL_XA:  state_r <= ST_RND_S;
        ST_RND_S: begin
          term_r  <= TERM_COS_FIRST;
          state_r <= ST_RCP;
        end
        ST_RND_C: state_r <= ST_FOLD;
        ST_FOLD:  state_r <= (job_r == JOB_ELEV) ? ST_STORE_ELEV : ST_SPR_MUL;
        ST_STORE_ELEV: state_r <= ST_IDLE;
        ST_SPR_MUL: state_r <= ST_SPR_RND;
        ST_SPR_RND: begin
          term_r  <= '0;
          state_r <= ST_RM_MUL;
        end
        ST_RM_MUL: state_r <= ST_RM_RND;
        ST_RM_RND: begin
          if (term_r == 3'd3) begin
            state_r <= ST_PUBLISH;
          end else begin
            term_r  <= term_r + 3'd1;
            state_r <= ST_RM_MUL;
          end
        end
        ST_PUBLISH: begin
          if (pub_ok) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ring_point_emitter.sv
// Top level of the ring point emitter: controller, datapath and stream ports.
//
// Each input request yields one particle: a position on the ring and a unit launch velocity.
// Each item is sequenced through one shared 32x32 multiplier, which steps through the
// octant-reduced sine and cosine series, the spread product and then the four rounded
// output products. A finished result waits in the output register while the next item
// is taken. A write of elevation_degrees keeps both ready lines low during one reciprocal
// multiply for the turn fraction and then the series; a write of steps_per_turn keeps
// them low while a 33-step divider computes the phase increment. The other two
// registers take effect at once. While cfg_valid is high, input waits.
module ring_point_emitter
  import rpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // random_phase[15:0], random_jitter[31:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [87:0]           out_tdata,  // pos_x[17:0], pos_y[35:18], vel_x[51:36],
                                            // vel_y[67:52], vel_z[83:68], zero[87:84]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t            cmd;
  dp_status_t         status;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;

  rpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .status     (status),
    .cmd        (cmd)
  );

  rpe_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_random_phase  (in_tdata[15:0]),
    .in_random_jitter (signed'(in_tdata[31:16])),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .vel_x            (vel_x),
    .vel_y            (vel_y),
    .vel_z            (vel_z)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {4'h0, vel_z, vel_y, vel_x, pos_y, pos_x};

endmodule

FILE: rtl/rpe_checker.sv
// Port-level checker for the ring point emitter, bound to the top level.
module rpe_checker
  import rpe_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [31:0]           in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [87:0]           out_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration requests take priority over input
  a_cfg_priority: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !in_tready)
    else $error("input ready while a configuration request waits");

  // An accepted item blocks both request channels
  a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !cfg_ready))
    else $error("block ready right after accepting an item");

  // An elevation write starts the elevation job
  a_elev_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == REG_ELEVATION)) |=> !cfg_ready)
    else $error("configuration ready right after an elevation write");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

  // Vertical velocity stays a unit component
  a_vel_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[83:68]) <= 16'sd16384) &&
                    ($signed(out_tdata[83:68]) >= -16'sd16384)))
    else $error("vel_z outside the unit range");

endmodule

bind ring_point_emitter rpe_checker u_rpe_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the ring point emitter: stream driver, monitor and particle predictor.
`timescale 1ns / 1ps

module tb_top;
  import rpe_pkg::*;

  localparam int TARGET_ITEMS   = 1500;
  localparam int STALL_LIMIT    = 3000;
  localparam int TAIL_CYCLES    = 60;
  localparam int IDLE_PERCENT   = 21;

  // Result layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] vel_z;
    logic [15:0] vel_y;
    logic [15:0] vel_x;
    logic [17:0] pos_y;
    logic [17:0] pos_x;
  } particle_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;   // random_phase[15:0], random_jitter[31:16]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [87:0]           out_tdata;         // pos_x, pos_y, vel_x, vel_y, vel_z, zero pad
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Predictor copy of the settings and the phase accumulator
  logic [15:0] set_radius = 16'd256;
  logic [15:0] set_jitter = 16'd0;
  logic [8:0]  set_elev   = 9'd0;
  logic [15:0] set_steps  = 16'd0;
  logic [15:0] cur_phase  = 16'd0;
  logic [16:0] phase_step = 17'd0;

  logic [31:0] request_queue[$];
  particle_t   particle_due[$];
  particle_t   got, want;

  logic steady = 1'b0;
  int   mismatch_count   = 0;
  int   requests_taken   = 0;
  int   particles_seen   = 0;
  int   requests_queued  = 0;
  int   reg_writes       = 0;
  int   batches          = 0;
  int   stall_cycles     = 0;
  int   elev_marks[15]   = '{0, 89, 90, 91, 179, 180, 181, 269, 270, 271,
                             359, 360, 449, 450, 511};

  ring_point_emitter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Q2.30 product
  function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // Product scaled by 2^-sh, rounded half away from zero
  function automatic logic signed [31:0] round_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input int sh);
    logic signed [63:0] wa, wb;
    logic [63:0] ma, mb, q;
    logic neg;
    wa  = a;
    wb  = b;
    neg = (wa < 0) != (wb < 0);
    ma  = (wa < 0) ? -wa : wa;
    mb  = (wb < 0) ? -wb : wb;
    q   = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // Sine and cosine of a 24 bit turn fraction, Q1.14, via octant folding and series
  function automatic void turn_sincos(input logic [23:0] t,
                                      output logic signed [15:0] sn,
                                      output logic signed [15:0] cs);
    logic [2:0]  oct;
    logic [63:0] r, x, x2, s, c;
    logic signed [15:0] sq, cq;
    oct = t[23:21];
    r   = {43'd0, t[20:0]};
    if (oct[0]) r = 64'h20_0000 - r;
    x  = (r * 64'd843314857) >> 21;
    x2 = mul30(x, x);
    s  = 64'h4000_0000 - x2 / 72;
    s  = 64'h4000_0000 - mul30(x2, s) / 42;
    s  = 64'h4000_0000 - mul30(x2, s) / 20;
    s  = 64'h4000_0000 - mul30(x2, s) / 6;
    s  = mul30(x, s);
    c  = 64'h4000_0000 - x2 / 56;
    c  = 64'h4000_0000 - mul30(x2, c) / 30;
    c  = 64'h4000_0000 - mul30(x2, c) / 12;
    c  = 64'h4000_0000 - mul30(x2, c) / 2;
    sq = 16'((s + 64'd32768) >> 16);
    cq = 16'((c + 64'd32768) >> 16);
    case (oct)
      3'd0:    begin sn = sq;  cs = cq;  end
      3'd1:    begin sn = cq;  cs = sq;  end
      3'd2:    begin sn = cq;  cs = -sq; end
      3'd3:    begin sn = sq;  cs = -cq; end
      3'd4:    begin sn = -sq; cs = -cq; end
      3'd5:    begin sn = -cq; cs = -sq; end
      3'd6:    begin sn = -cq; cs = sq;  end
      default: begin sn = -sq; cs = cq;  end
    endcase
  endfunction

  // Advance the phase and build the particle for one accepted request
  function automatic particle_t predict_particle(input logic [15:0] rnd_phase,
                                                 input logic [15:0] rnd_jitter);
    logic signed [31:0] jr, spread, reff, h;
    logic signed [15:0] ring_s, ring_c, elev_s, elev_c;
    logic [63:0] elev_turn;
    logic [8:0]  dm;
    particle_t   p;
    if (set_steps != 16'd0) cur_phase = 16'({1'b0, cur_phase} + phase_step);
    else cur_phase = rnd_phase;
    jr     = $signed({{16{rnd_jitter[15]}}, rnd_jitter});
    spread = round_mul($signed({16'd0, set_jitter}), jr, 15);
    reff   = $signed({16'd0, set_radius}) + spread;
    turn_sincos({cur_phase, 8'h00}, ring_s, ring_c);
    dm        = set_elev % 9'd360;
    elev_turn = ((64'(dm) << 24) + 64'd180) / 64'd360;
    turn_sincos(elev_turn[23:0], elev_s, elev_c);
    h = elev_c;
    if (h < 0) h = -h;
    // Back half of the elevation circle flips the horizontal part
    if (set_elev > 9'd90 && set_elev < 9'd270) h = -h;
    p.pad   = 4'd0;
    p.pos_x = 18'(round_mul(ring_c, reff, 14));
    p.pos_y = 18'(round_mul(ring_s, reff, 14));
    p.vel_x = 16'(round_mul(ring_c, h, 14));
    p.vel_y = 16'(round_mul(ring_s, h, 14));
    p.vel_z = elev_s;
    return p;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: present queued requests, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        particle_due.push_back(predict_particle(in_tdata[15:0], in_tdata[31:16]));
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_tdata  <= request_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      particles_seen++;
      got = out_tdata;
      if (particle_due.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result %h with no request pending", $time, out_tdata);
      end else begin
        want = particle_due.pop_front();
        check_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
        check_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
        check_field("vel_x", 32'(want.vel_x), 32'(got.vel_x));
        check_field("vel_y", 32'(want.vel_y), 32'(got.vel_y));
        check_field("vel_z", 32'(want.vel_z), 32'(got.vel_z));
        check_field("pad",   32'(want.pad),   32'(got.pad));
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, stall_cycles);
      $display("FAIL ring_point_emitter");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Write one register and mirror it in the predictor
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_RING_RADIUS:   set_radius = val;
      REG_RADIUS_JITTER: set_jitter = val;
      REG_ELEVATION:     set_elev   = val[8:0];
      REG_STEPS: begin
        set_steps  = val;
        phase_step = (val == 16'd0) ? 17'd0 : 17'((32'h1_0000 + val / 2) / val);
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic [15:0] ph, input logic [15:0] jit);
    request_queue.push_back({jit, ph});
    requests_queued++;
  endtask

  // Hold until every request is taken and every result has come back
  task automatic drain();
    while (request_queue.size() != 0 || in_tvalid || particle_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return 16'h0000;
    if (roll < 24) return 16'hFFFF;
    if (roll < 50) return 16'($urandom_range(1023));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_steps();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return 16'd0;
    if (roll < 45) return 16'd1;
    if (roll < 70) return 16'($urandom_range(2, 12));
    if (roll < 78) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    int n;
    bit wrote;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: random phase, radius 256, no jitter, flat elevation
    queue_item(16'h0000, 16'h0000);
    queue_item(16'h2000, 16'h7FFF);
    queue_item(16'hFFFF, 16'h8000);
    queue_item(16'h6000, 16'h1234);
    drain();

    // Largest radius and jitter, jitter at both ends
    set_reg(REG_RING_RADIUS, 16'hFFFF);
    set_reg(REG_RADIUS_JITTER, 16'hFFFF);
    queue_item(16'h4000, 16'h7FFF);
    queue_item(16'h8000, 16'h8000);
    queue_item(16'hC000, 16'h0000);
    queue_item(16'hA000, 16'hFFFF);
    drain();

    // Zero radius, so the effective radius goes negative
    set_reg(REG_RING_RADIUS, 16'h0000);
    queue_item(16'hE000, 16'h8000);
    queue_item(16'h1000, 16'h7FFF);
    drain();

    // Elevations around the flip boundaries and past 359
    set_reg(REG_RING_RADIUS, 16'h0100);
    set_reg(REG_RADIUS_JITTER, 16'h0080);
    foreach (elev_marks[i]) begin
      if (elev_marks[i] inside {90, 91, 180, 269, 270, 359, 360, 511}) begin
        set_reg(REG_ELEVATION, 16'(elev_marks[i]));
        queue_item(16'($urandom), 16'($urandom));
        drain();
      end
    end

    // One step per turn holds the phase; largest step count moves it by one
    set_reg(REG_STEPS, 16'd1);
    repeat (3) queue_item(16'($urandom), 16'($urandom));
    drain();
    set_reg(REG_STEPS, 16'hFFFF);
    repeat (2) queue_item(16'($urandom), 16'($urandom));
    drain();
    set_reg(REG_STEPS, 16'd3);
    repeat (2) queue_item(16'($urandom), 16'($urandom));
    drain();

    // Random settings, each followed by a batch of random requests
    while (requests_queued < TARGET_ITEMS) begin
      wrote = 1'b0;
      if ($urandom_range(99) < 60) begin
        set_reg(REG_RING_RADIUS, pick_level());
        wrote = 1'b1;
      end
      if ($urandom_range(99) < 60) begin
        set_reg(REG_RADIUS_JITTER, pick_level());
        wrote = 1'b1;
      end
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(1)) set_reg(REG_ELEVATION, 16'(elev_marks[$urandom_range(14)]));
        else set_reg(REG_ELEVATION, 16'($urandom_range(511)));
        wrote = 1'b1;
      end
      if (!wrote || $urandom_range(99) < 60) set_reg(REG_STEPS, pick_steps());
      steady = (batches == 4);
      n = $urandom_range(90, 140);
      repeat (n) queue_item(16'($urandom), 16'($urandom));
      drain();
      batches++;
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests in %0d random batches with %0d register writes;",
             requests_taken, batches, reg_writes);
    $display("%0d particles compared, %0d field mismatches.", particles_seen, mismatch_count);
    if (mismatch_count == 0 && particle_due.size() == 0) begin
      $display("PASS ring_point_emitter");
    end else begin
      $display("FAIL ring_point_emitter");
    end
    $finish;
  end

endmodule
